// ----- hdl/integer_to_radix_ascii_assert.svh -----
// Assertion macros used by the checker file of the radix formatter.
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define I2RA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define I2RA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/i2ra_pkg.sv -----
// Package of the radix formatter: widths, character codes, types and helpers.
package i2ra_pkg;

    localparam int VALUE_W    = 64;
    localparam int VALUE_BITS = 64;
    localparam int CHAR_BITS  = 8;
    localparam int DIGIT_BITS = 4;
    localparam int MAX_DIGITS = 64;
    localparam int ADDR_BITS  = $clog2(MAX_DIGITS);
    localparam int COUNT_BITS = ADDR_BITS + 1;

    // The decimal divider eats one byte of the working value per cycle.
    localparam int DEC_BITS   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int DEC_STEPS  = DEC_BITS / 8;
    localparam int STEP_BITS  = (DEC_STEPS > 1) ? $clog2(DEC_STEPS) : 1;

    localparam logic [COUNT_BITS-1:0] FULL_BIN = COUNT_BITS'(VALUE_BITS);
    localparam logic [COUNT_BITS-1:0] FULL_OCT = COUNT_BITS'((VALUE_BITS + 2) / 3);
    localparam logic [COUNT_BITS-1:0] FULL_HEX = COUNT_BITS'((VALUE_BITS + 3) / 4);
    localparam logic [COUNT_BITS-1:0] COUNT_CAP = COUNT_BITS'(MAX_DIGITS);

    localparam logic [CHAR_BITS-1:0] CH_B    = 8'd98;
    localparam logic [CHAR_BITS-1:0] CH_O    = 8'd111;
    localparam logic [CHAR_BITS-1:0] CH_D    = 8'd100;
    localparam logic [CHAR_BITS-1:0] CH_X    = 8'd120;
    localparam logic [CHAR_BITS-1:0] CH_0    = 8'd48;
    localparam logic [CHAR_BITS-1:0] CH_NEG  = 8'd45;
    localparam logic [CHAR_BITS-1:0] HEX_GAP = 8'd39;

    typedef enum logic [1:0] {
        BASE_BIN,
        BASE_OCT,
        BASE_DEC,
        BASE_HEX
    } base_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_ERROR
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic read;
        logic out_load;
        logic err_load;
    } dp_cmd_t;

    typedef struct packed {
        logic base_ok;
        logic digit_done;
        logic more;
        logic out_free;
        logic emit_last;
    } dp_status_t;

    function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] ext;
        ext = CHAR_BITS'(d);
        if (d < 4'd10)
        begin
            return CH_0 + ext;
        end
        return CH_0 + ext + HEX_GAP;
    endfunction

endpackage

// ----- hdl/i2ra_if.sv -----
// Request and result channel interfaces of the radix formatter.
interface i2ra_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [i2ra_pkg::VALUE_W-1:0]    value;
    logic [i2ra_pkg::CHAR_BITS-1:0]         base_char;

    modport source (output valid, output value, output base_char, input ready);
    modport sink   (input valid, input value, input base_char, output ready);
endinterface

interface i2ra_out_if;
    logic                           valid;
    logic                           ready;
    logic [i2ra_pkg::CHAR_BITS-1:0] prefix_char;
    logic [i2ra_pkg::CHAR_BITS-1:0] digit_char;
    logic                           last;
    logic                           bad_base;

    modport source (output valid, output prefix_char, output digit_char, output last,
                    output bad_base, input ready);
    modport sink   (input valid, input prefix_char, input digit_char, input last,
                    input bad_base, output ready);
endinterface

// ----- hdl/i2ra_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module i2ra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/i2ra_ctrl.sv -----
// Controller of the radix formatter: sequences extraction and emission.
module i2ra_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  i2ra_pkg::dp_status_t  status,
    output i2ra_pkg::dp_cmd_t     cmd
);

    i2ra_pkg::state_t state_reg;
    i2ra_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2ra_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            i2ra_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.base_ok)
                    begin
                        cmd.load   = 1'b1;
                        state_next = i2ra_pkg::ST_EXTRACT;
                    end
                    else
                    begin
                        state_next = i2ra_pkg::ST_ERROR;
                    end
                end
            end
            i2ra_pkg::ST_EXTRACT:
            begin
                cmd.step = 1'b1;
                if (status.digit_done && !status.more)
                begin
                    state_next = i2ra_pkg::ST_EMIT_RD;
                end
            end
            i2ra_pkg::ST_EMIT_RD:
            begin
                cmd.read   = 1'b1;
                state_next = i2ra_pkg::ST_EMIT_WR;
            end
            i2ra_pkg::ST_EMIT_WR:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.emit_last ? i2ra_pkg::ST_IDLE
                                                    : i2ra_pkg::ST_EMIT_RD;
                end
            end
            i2ra_pkg::ST_ERROR:
            begin
                if (status.out_free)
                begin
                    cmd.err_load = 1'b1;
                    state_next   = i2ra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = i2ra_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/i2ra_dp.sv -----
// Datapath of the radix formatter: digit extraction, digit store and result register.
module i2ra_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [i2ra_pkg::VALUE_W-1:0]  value,
    input  logic [i2ra_pkg::CHAR_BITS-1:0]       base_char,
    input  i2ra_pkg::dp_cmd_t                    cmd,
    output i2ra_pkg::dp_status_t                 status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [i2ra_pkg::CHAR_BITS-1:0]       prefix_char,
    output logic [i2ra_pkg::CHAR_BITS-1:0]       digit_char,
    output logic                                 last,
    output logic                                 bad_base
);

    localparam int DB = i2ra_pkg::DEC_BITS;
    localparam int VB = i2ra_pkg::VALUE_BITS;
    localparam int CB = i2ra_pkg::COUNT_BITS;
    localparam int AB = i2ra_pkg::ADDR_BITS;
    localparam int GB = i2ra_pkg::DIGIT_BITS;
    localparam int SB = i2ra_pkg::STEP_BITS;
    localparam logic [SB-1:0] LAST_STEP = SB'(i2ra_pkg::DEC_STEPS - 1);

    // Working registers.
    logic [DB-1:0]                   work_reg;
    logic [GB-1:0]                   rem_reg;
    logic [SB-1:0]                   sub_reg;
    logic [CB-1:0]                   count_reg;
    logic                            neg_reg;
    i2ra_pkg::base_t                 base_reg;
    logic [i2ra_pkg::CHAR_BITS-1:0]  prefix_reg;

    // Result register.
    logic                            out_valid_reg;
    logic [i2ra_pkg::CHAR_BITS-1:0]  out_prefix_reg;
    logic [i2ra_pkg::CHAR_BITS-1:0]  out_digit_reg;
    logic                            out_last_reg;
    logic                            out_bad_reg;

    // Input decode.
    logic                            base_ok;
    i2ra_pkg::base_t                 base_kind;
    logic [VB-1:0]                   raw;
    logic [VB-1:0]                   mag;
    logic                            neg_in;
    logic                            dec_neg;

    // Extraction step.
    logic [7:0]                      qbyte;
    logic [GB-1:0]                   dec_rem;
    logic [DB-1:0]                   dec_work_next;
    logic [GB-1:0]                   pw_digit;
    logic [DB-1:0]                   pw_work_next;
    logic [CB-1:0]                   full;
    logic                            is_dec;
    logic                            digit_done;
    logic [DB-1:0]                   work_next;
    logic [GB-1:0]                   wr_digit;
    logic [CB-1:0]                   count_inc;
    logic [CB-1:0]                   count_dec;
    logic                            more;
    logic [AB-1:0]                   rd_addr;
    logic [GB-1:0]                   rd_digit;

    always_comb
    begin
        base_ok   = 1'b1;
        base_kind = i2ra_pkg::BASE_DEC;
        case (base_char)
            i2ra_pkg::CH_B: base_kind = i2ra_pkg::BASE_BIN;
            i2ra_pkg::CH_O: base_kind = i2ra_pkg::BASE_OCT;
            i2ra_pkg::CH_D: base_kind = i2ra_pkg::BASE_DEC;
            i2ra_pkg::CH_X: base_kind = i2ra_pkg::BASE_HEX;
            default:        base_ok   = 1'b0;
        endcase
    end

    assign raw     = value[VB-1:0];
    assign neg_in  = raw[VB-1];
    assign mag     = ~raw + 1'b1;
    assign dec_neg = neg_in && (base_kind == i2ra_pkg::BASE_DEC);

    // Restoring division by ten, eight quotient bits per cycle; the remainder
    // carries from one byte to the next and is the digit after the last byte.
    always_comb
    begin
        logic [GB-1:0] r;
        logic [GB:0]   t;
        r     = rem_reg;
        qbyte = '0;
        for (int i = 0; i < 8; i++)
        begin
            t = {r, work_reg[DB-1-i]};
            if (t >= 5'd10)
            begin
                qbyte[7-i] = 1'b1;
                r          = GB'(t - 5'd10);
            end
            else
            begin
                r = t[GB-1:0];
            end
        end
        dec_rem       = r;
        dec_work_next = (work_reg << 8) | DB'(qbyte);
    end

    always_comb
    begin
        case (base_reg)
            i2ra_pkg::BASE_BIN:
            begin
                pw_digit     = GB'(work_reg[0]);
                pw_work_next = work_reg >> 1;
                full         = i2ra_pkg::FULL_BIN;
            end
            i2ra_pkg::BASE_OCT:
            begin
                pw_digit     = GB'(work_reg[2:0]);
                pw_work_next = work_reg >> 3;
                full         = i2ra_pkg::FULL_OCT;
            end
            default:
            begin
                pw_digit     = work_reg[3:0];
                pw_work_next = work_reg >> 4;
                full         = i2ra_pkg::FULL_HEX;
            end
        endcase
    end

    assign is_dec     = (base_reg == i2ra_pkg::BASE_DEC);
    assign digit_done = is_dec ? (sub_reg == LAST_STEP) : 1'b1;
    assign work_next  = is_dec ? dec_work_next : pw_work_next;
    assign wr_digit   = is_dec ? dec_rem : pw_digit;
    assign count_inc  = count_reg + 1'b1;
    assign count_dec  = count_reg - 1'b1;

    // A negative value in a power-of-two base keeps every digit of its width.
    assign more = (count_inc < i2ra_pkg::COUNT_CAP) &&
                  ((!is_dec && neg_reg) ? (count_inc < full) : (work_next != '0));

    // Outside the read cycle the address stays on the digit being shown, so a
    // stalled result keeps reading the same entry.
    assign rd_addr = cmd.read ? count_dec[AB-1:0] : count_reg[AB-1:0];

    i2ra_ram #(
        .WIDTH (GB),
        .DEPTH (i2ra_pkg::MAX_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.step && digit_done),
        .waddr (count_reg[AB-1:0]),
        .wdata (wr_digit),
        .raddr (rd_addr),
        .rdata (rd_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= '0;
                sub_reg   <= '0;
            end
            else if (cmd.step)
            begin
                if (digit_done)
                begin
                    count_reg <= count_inc;
                    sub_reg   <= '0;
                end
                else
                begin
                    sub_reg <= sub_reg + 1'b1;
                end
            end
            else if (cmd.read)
            begin
                count_reg <= count_dec;
            end

            if (cmd.out_load || cmd.err_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg   <= DB'(dec_neg ? mag : raw);
            rem_reg    <= '0;
            neg_reg    <= neg_in;
            base_reg   <= base_kind;
            prefix_reg <= dec_neg ? i2ra_pkg::CH_NEG : base_char;
        end
        else if (cmd.step)
        begin
            work_reg <= work_next;
            rem_reg  <= digit_done ? '0 : dec_rem;
        end

        if (cmd.out_load)
        begin
            out_prefix_reg <= prefix_reg;
            out_digit_reg  <= i2ra_pkg::digit_ascii(rd_digit);
            out_last_reg   <= (count_reg == '0);
            out_bad_reg    <= 1'b0;
        end
        else if (cmd.err_load)
        begin
            out_prefix_reg <= '0;
            out_digit_reg  <= '0;
            out_last_reg   <= 1'b1;
            out_bad_reg    <= 1'b1;
        end
    end

    assign status.base_ok    = base_ok;
    assign status.digit_done = digit_done;
    assign status.more       = more;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.emit_last  = (count_reg == '0);

    assign out_valid   = out_valid_reg;
    assign prefix_char = out_prefix_reg;
    assign digit_char  = out_digit_reg;
    assign last        = out_last_reg;
    assign bad_base    = out_bad_reg;

endmodule

// ----- hdl/integer_to_radix_ascii.sv -----
// Top level of the radix formatter: controller, datapath and channel hookup.
//
//   channel  role    payload
//   din      sink    value (64, signed), base_char (8)
//   dout     source  prefix_char (8), digit_char (8), last (1), bad_base (1)
//
// A request is taken, then digits are extracted least significant first: each
// extraction step gives a digit in binary, octal and hex, while in decimal the
// divide-by-ten unit handles one byte a cycle, a digit after the last byte (up
// to 19 digits). Each digit then leaves through the digit store read port and
// the result register. A bad base gives one result with no extraction. Reset
// clears the control state, the digit counters and the result valid flag only;
// a stalled result register holds emission at that point.
module integer_to_radix_ascii (
    input  logic        clk,
    input  logic        rst_n,
    i2ra_in_if.sink     din,
    i2ra_out_if.source  dout
);

    i2ra_pkg::dp_cmd_t    cmd;
    i2ra_pkg::dp_status_t status;

    i2ra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .status   (status),
        .cmd      (cmd)
    );

    i2ra_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (din.value),
        .base_char   (din.base_char),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (dout.ready),
        .out_valid   (dout.valid),
        .prefix_char (dout.prefix_char),
        .digit_char  (dout.digit_char),
        .last        (dout.last),
        .bad_base    (dout.bad_base)
    );

endmodule

// ----- hdl/i2ra_checker.sv -----
// Port-level checker of the radix formatter and its bind to the top level.
`include "integer_to_radix_ascii_assert.svh"

module i2ra_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       din_valid,
    input logic       din_ready,
    input logic       dout_valid,
    input logic       dout_ready,
    input logic [7:0] prefix_char,
    input logic [7:0] digit_char,
    input logic       last,
    input logic       bad_base
);

    `I2RA_ASSERT_NXT(a_out_hold, dout_valid && !dout_ready, dout_valid && $stable(digit_char) && $stable(prefix_char) && $stable(last), "stalled result changed")

    `I2RA_ASSERT_IMP(a_bad_shape, dout_valid && bad_base, last && digit_char == 8'd0 && prefix_char == 8'd0, "bad base result malformed")

    `I2RA_ASSERT_IMP(a_digit_set, dout_valid && !bad_base, (digit_char >= 8'd48 && digit_char <= 8'd57) || (digit_char >= 8'd97 && digit_char <= 8'd102), "digit out of range")

    `I2RA_ASSERT_NXT(a_one_at_time, din_valid && din_ready, !din_ready, "second request taken while busy")

endmodule

bind integer_to_radix_ascii i2ra_checker u_i2ra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .din_valid   (din.valid),
    .din_ready   (din.ready),
    .dout_valid  (dout.valid),
    .dout_ready  (dout.ready),
    .prefix_char (dout.prefix_char),
    .digit_char  (dout.digit_char),
    .last        (dout.last),
    .bad_base    (dout.bad_base)
);
